// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- src/lkdv_pkg.sv -----
package lkdv_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] CHECK_BYTES = 6'd31;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY_A1      = 2'd0;
  localparam logic [1:0] CFG_KEY_A2      = 2'd1;
  localparam logic [1:0] CFG_KEY_B       = 2'd2;
  localparam logic [1:0] CFG_CIPHER_MODE = 2'd3;

  // Cipher mode bits
  localparam int unsigned MODE_BIT_DOUBLE = 0;
  localparam int unsigned MODE_BIT_POLY   = 1;

  localparam logic [31:0] RST_KEY_A1 = 32'h383477BC;
  localparam logic [31:0] RST_KEY_A2 = 32'h383477BC;
  localparam logic [31:0] RST_KEY_B  = 32'h02345CC6;

  typedef enum logic [1:0] {
    VERDICT_PENDING  = 2'd0,
    VERDICT_MATCHED  = 2'd1,
    VERDICT_REJECTED = 2'd2
  } verdict_t;

  // Seed expansion masks
  localparam logic [15:0] SEED_K1_HI = 16'h1357;
  localparam logic [15:0] SEED_K1_LO = 16'hAAAA;
  localparam logic [15:0] SEED_K2_HI = 16'hABCD;
  localparam logic [15:0] SEED_K2_LO = 16'h4321;

  // Plaintext check
  localparam logic [7:0] PLAIN_MARK = 8'h80;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;

  // Polynomial update constants
  localparam logic [31:0] POLY_N2A = 32'h387FC5CC;
  localparam logic [31:0] POLY_N2M = 32'h35CE9581;
  localparam logic [31:0] POLY_N2B = 32'h07AFCC37;
  localparam logic [31:0] POLY_N1A = 32'h021510C6;
  localparam logic [31:0] POLY_N1M = 32'h4C3A1353;
  localparam logic [31:0] POLY_N1B = 32'h16EF783F;

  typedef enum logic [3:0] {
    PS_IDLE,
    PS_K1SQ,
    PS_K2SQ,
    PS_N2BASE,
    PS_N2T,
    PS_N2SUM,
    PS_N2SQ,
    PS_N1W,
    PS_N1SUB,
    PS_DONE
  } poly_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } poly_status_t;

endpackage

// ----- src/lkdv_mul.sv -----
module lkdv_mul (
  input  logic                         clk,
  input  logic [lkdv_pkg::KEY_W-1:0]   a,
  input  logic [lkdv_pkg::KEY_W-1:0]   b,
  output logic [lkdv_pkg::KEY_W-1:0]   prod
);

  logic [2*lkdv_pkg::KEY_W-1:0] full;

  assign full = {{lkdv_pkg::KEY_W{1'b0}}, a} * {{lkdv_pkg::KEY_W{1'b0}}, b};

  // Only the low word is ever needed (mod 2^32)
  always_ff @(posedge clk) begin
    prod <= full[lkdv_pkg::KEY_W-1:0];
  end

endmodule

// ----- src/lkdv_poly.sv -----
module lkdv_poly (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lkdv_pkg::KEY_W-1:0]   key_one_in,
  input  logic [lkdv_pkg::KEY_W-1:0]   key_two_in,
  output lkdv_pkg::poly_status_t       status,
  output logic [lkdv_pkg::KEY_W-1:0]   key_one_out,
  output logic [lkdv_pkg::KEY_W-1:0]   key_two_out
);

  lkdv_pkg::poly_state_t state, state_next;

  logic [lkdv_pkg::KEY_W-1:0] prod;
  logic [lkdv_pkg::KEY_W-1:0] mul_a, mul_b;
  logic [lkdv_pkg::KEY_W-1:0] acc, acc_next;
  logic [lkdv_pkg::KEY_W-1:0] k1sq, k1sq_next;
  logic [lkdv_pkg::KEY_W-1:0] n2, n2_next;
  logic [4:0] sh_k2, sh_k1;

  lkdv_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Low five bits of x*5 and x*3 only depend on the low five bits of x
  assign sh_k2 = prod[4:0] + {prod[2:0], 2'b00};
  assign sh_k1 = k1sq[4:0] + {k1sq[3:0], 1'b0};

  always_comb begin
    state_next = state;
    unique case (state)
      lkdv_pkg::PS_IDLE:   if (start) state_next = lkdv_pkg::PS_K1SQ;
      lkdv_pkg::PS_K1SQ:   state_next = lkdv_pkg::PS_K2SQ;
      lkdv_pkg::PS_K2SQ:   state_next = lkdv_pkg::PS_N2BASE;
      lkdv_pkg::PS_N2BASE: state_next = lkdv_pkg::PS_N2T;
      lkdv_pkg::PS_N2T:    state_next = lkdv_pkg::PS_N2SUM;
      lkdv_pkg::PS_N2SUM:  state_next = lkdv_pkg::PS_N2SQ;
      lkdv_pkg::PS_N2SQ:   state_next = lkdv_pkg::PS_N1W;
      lkdv_pkg::PS_N1W:    state_next = lkdv_pkg::PS_N1SUB;
      lkdv_pkg::PS_N1SUB:  state_next = lkdv_pkg::PS_DONE;
      lkdv_pkg::PS_DONE:   state_next = lkdv_pkg::PS_IDLE;
      default:             state_next = lkdv_pkg::PS_IDLE;
    endcase
  end

  // prod always holds the product requested in the previous state
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    acc_next    = acc;
    k1sq_next   = k1sq;
    n2_next     = n2;
    status.busy = (state != lkdv_pkg::PS_IDLE);
    status.done = 1'b0;
    key_one_out = acc + prod;
    key_two_out = n2;
    unique case (state)
      lkdv_pkg::PS_IDLE: begin
        mul_a = key_one_in;
        mul_b = key_one_in;
      end
      lkdv_pkg::PS_K1SQ: begin
        // prod = k1^2 here
        k1sq_next = prod;
        mul_a     = key_two_in;
        mul_b     = key_two_in;
      end
      lkdv_pkg::PS_K2SQ: begin
        // keep k2^2 on the multiplier for the next state
        mul_a = key_two_in;
        mul_b = key_two_in;
      end
      lkdv_pkg::PS_N2BASE: begin
        // prod = k2^2 here
        acc_next = (lkdv_pkg::POLY_N2A >> sh_k2) + lkdv_pkg::POLY_N2B;
        mul_a    = key_two_in;
        mul_b    = lkdv_pkg::POLY_N2A;
      end
      lkdv_pkg::PS_N2T: begin
        acc_next = acc + prod;
        mul_a    = k1sq;
        mul_b    = lkdv_pkg::POLY_N2M;
      end
      lkdv_pkg::PS_N2SUM: begin
        n2_next = acc + prod;
      end
      lkdv_pkg::PS_N2SQ: begin
        mul_a    = n2;
        mul_b    = n2;
        acc_next = (lkdv_pkg::POLY_N1A >> sh_k1) + lkdv_pkg::POLY_N1B;
      end
      lkdv_pkg::PS_N1W: begin
        mul_a = prod;
        mul_b = lkdv_pkg::POLY_N1M;
      end
      lkdv_pkg::PS_N1SUB: begin
        acc_next = acc - prod;
        mul_a    = key_one_in;
        mul_b    = lkdv_pkg::POLY_N1A;
      end
      lkdv_pkg::PS_DONE: begin
        status.done = 1'b1;
      end
      default: begin
        status.busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkdv_pkg::PS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    acc  <= acc_next;
    k1sq <= k1sq_next;
    n2   <= n2_next;
  end

endmodule

// ----- src/login_keystream_decrypt_validate_core.sv -----
// Login keystream decryptor and checker.
// Input channel (in_valid/in_stall): command, seed, data_byte, last_byte.
// A start command loads both keys from the seed and clears the check; a data
// command decrypts data_byte with the low byte of key one and checks it.
// Output channel (out_valid/out_stall): one transaction per input item with
// plain_byte (zero on start) and verdict after that item.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes key_a1,
// key_a2, key_b and cipher_mode; cfg_ready is always high.
// The result is registered and shows in the cycle after the input transaction.
// Start items and shift-mode data items do not stall the input. In
// polynomial mode a data item holds the input stalled while the key
// update runs seven products through the one multiplier.
// Reset clears the keys, byte position and verdict and loads the config
// reset values. A stalled result holds in the output register; the input
// is stalled while that result waits and cannot be taken in the same cycle.
module login_keystream_decrypt_validate_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] seed,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  plain_byte,
  output logic [1:0]  verdict,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  `include "assert_macros.svh"

  logic [31:0] key_a1, key_a2, key_b;
  logic [1:0]  cipher_mode;

  logic [31:0] key_one, key_one_next;
  logic [31:0] key_two, key_two_next;
  logic [lkdv_pkg::POS_W-1:0] byte_position, byte_position_next;
  lkdv_pkg::verdict_t check_state, check_state_next;

  logic        in_accept, is_data, poly_start, mode_poly, plain_ok;
  logic [7:0]  plain;
  logic [31:0] seed_inv, t_one, t_two;
  logic [31:0] poly_key_one, poly_key_two;
  lkdv_pkg::poly_status_t poly_st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a1      <= lkdv_pkg::RST_KEY_A1;
      key_a2      <= lkdv_pkg::RST_KEY_A2;
      key_b       <= lkdv_pkg::RST_KEY_B;
      cipher_mode <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lkdv_pkg::CFG_KEY_A1:      key_a1 <= cfg_data;
        lkdv_pkg::CFG_KEY_A2:      key_a2 <= cfg_data;
        lkdv_pkg::CFG_KEY_B:       key_b <= cfg_data;
        lkdv_pkg::CFG_CIPHER_MODE: cipher_mode <= cfg_data[1:0];
        default:                   cipher_mode <= cipher_mode;
      endcase
    end
  end

  assign in_stall   = poly_st.busy || (out_valid && out_stall);
  assign in_accept  = in_valid && !in_stall;
  assign is_data    = (command == lkdv_pkg::CMD_DATA);
  assign mode_poly  = cipher_mode[lkdv_pkg::MODE_BIT_POLY];
  assign poly_start = in_accept && is_data && mode_poly;

  lkdv_poly u_poly (
    .clk         (clk),
    .rst         (rst),
    .start       (poly_start),
    .key_one_in  (key_one),
    .key_two_in  (key_two),
    .status      (poly_st),
    .key_one_out (poly_key_one),
    .key_two_out (poly_key_two)
  );

  assign plain    = data_byte ^ key_one[7:0];
  assign plain_ok = (byte_position == '0) ? (plain == lkdv_pkg::PLAIN_MARK)
                  : ((plain == 8'h00) ||
                     ((plain >= lkdv_pkg::PRINT_LO) && (plain <= lkdv_pkg::PRINT_HI)));
  assign seed_inv = ~seed;

  // Shift-xor rounds: rotate right pulling the top bit from the other key
  always_comb begin
    t_one = {key_one[0], key_two[31:1]} ^ key_a1;
    t_two = t_one;
    if (cipher_mode[lkdv_pkg::MODE_BIT_DOUBLE]) begin
      t_two = {key_one[0], t_one[31:1]} ^ key_a2;
    end
  end

  always_comb begin
    key_one_next       = key_one;
    key_two_next       = key_two;
    byte_position_next = byte_position;
    check_state_next   = check_state;
    if (poly_st.done) begin
      key_one_next = poly_key_one;
      key_two_next = poly_key_two;
    end else if (in_accept && !is_data) begin
      key_one_next = {seed_inv[15:0] ^ lkdv_pkg::SEED_K1_HI,
                      seed[15:0] ^ lkdv_pkg::SEED_K1_LO};
      key_two_next = {seed_inv[31:16] ^ lkdv_pkg::SEED_K2_HI,
                      seed[31:16] ^ lkdv_pkg::SEED_K2_LO};
      byte_position_next = '0;
      check_state_next   = lkdv_pkg::VERDICT_PENDING;
    end else if (in_accept) begin
      if (check_state == lkdv_pkg::VERDICT_PENDING &&
          byte_position < lkdv_pkg::CHECK_BYTES) begin
        if (!plain_ok) begin
          check_state_next = lkdv_pkg::VERDICT_REJECTED;
        end else if (byte_position == lkdv_pkg::CHECK_BYTES - 1'b1) begin
          check_state_next = lkdv_pkg::VERDICT_MATCHED;
        end else if (last_byte) begin
          check_state_next = lkdv_pkg::VERDICT_REJECTED;
        end
      end
      if (byte_position < lkdv_pkg::CHECK_BYTES) begin
        byte_position_next = byte_position + 1'b1;
      end
      if (!mode_poly) begin
        key_two_next = t_two;
        key_one_next = {key_two[0], key_one[31:1]} ^ key_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_one       <= '0;
      key_two       <= '0;
      byte_position <= '0;
      check_state   <= lkdv_pkg::VERDICT_PENDING;
      out_valid     <= 1'b0;
    end else begin
      key_one       <= key_one_next;
      key_two       <= key_two_next;
      byte_position <= byte_position_next;
      check_state   <= check_state_next;
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      plain_byte <= is_data ? plain : 8'h00;
      verdict    <= check_state_next;
    end
  end

  `ASSERT_NEXT(a_poly_start_busy, clk, rst, poly_start, poly_st.busy,
    "polynomial unit did not start")
  `ASSERT_NEXT(a_poly_done_idle, clk, rst, poly_st.done, !poly_st.busy,
    "polynomial unit stayed busy after done")
  `ASSERT_NEXT(a_verdict_sticky, clk, rst,
    in_accept && is_data && check_state != lkdv_pkg::VERDICT_PENDING,
    check_state == $past(check_state), "final verdict changed on data")
  `ASSERT_SAME(a_pos_range, clk, rst, 1'b1, byte_position <= lkdv_pkg::CHECK_BYTES,
    "byte position past check length")

endmodule

// ----- tb/sv/lkdv_decrypt_monitor.sv -----
module lkdv_decrypt_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic [31:0] seed,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  plain_byte,
  input  logic [1:0]  verdict,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          outstanding,
  output int          mismatches,
  output int          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHECK_LEN = 31;
  localparam logic [7:0] MARK_BYTE = 8'h80;
  localparam logic [7:0] TEXT_LO   = 8'h20;
  localparam logic [7:0] TEXT_HI   = 8'h7E;

  localparam logic [31:0] P_N2A = 32'h387FC5CC;
  localparam logic [31:0] P_N2M = 32'h35CE9581;
  localparam logic [31:0] P_N2B = 32'h07AFCC37;
  localparam logic [31:0] P_N1A = 32'h021510C6;
  localparam logic [31:0] P_N1M = 32'h4C3A1353;
  localparam logic [31:0] P_N1B = 32'h16EF783F;

  typedef struct packed {
    logic [7:0]          plain;
    lkdv_pkg::verdict_t  verdict;
  } login_result_t;

  login_result_t awaited_results[$];

  logic [31:0] cur_a1, cur_a2, cur_b;
  logic [1:0]  cur_mode;
  logic [31:0] exp_key1, exp_key2;
  int          exp_pos;
  lkdv_pkg::verdict_t exp_verdict;
  int          err_count;
  int          seen_count;

  function automatic logic [63:0] advance_keys(input logic [31:0] k1, input logic [31:0] k2);
    logic [31:0] k1sq, k2sq, shf, n1, n2;
    if (cur_mode[lkdv_pkg::MODE_BIT_POLY]) begin
      k1sq = k1 * k1;
      k2sq = k2 * k2;
      shf  = k2sq * 32'd5;
      n2   = (P_N2A >> shf[4:0]) + k2 * P_N2A + k1sq * P_N2M + P_N2B;
      shf  = k1sq * 32'd3;
      n1   = (P_N1A >> shf[4:0]) - (n2 * n2) * P_N1M + k1 * P_N1A + P_N1B;
    end else begin
      n2 = {k1[0], k2[31:1]} ^ cur_a1;
      // second round still rotates in the old key1 lsb
      if (cur_mode[lkdv_pkg::MODE_BIT_DOUBLE]) n2 = {k1[0], n2[31:1]} ^ cur_a2;
      n1 = {k2[0], k1[31:1]} ^ cur_b;
    end
    return {n1, n2};
  endfunction

  function automatic login_result_t decrypt_and_judge(input logic cmd, input logic [31:0] s,
                                                      input logic [7:0] d, input logic l);
    login_result_t r;
    logic [7:0] p;
    logic ok;
    r.plain = 8'h00;
    if (cmd == lkdv_pkg::CMD_START) begin
      exp_key1    = {~s[15:0] ^ 16'h1357, s[15:0] ^ 16'hAAAA};
      exp_key2    = {~s[31:16] ^ 16'hABCD, s[31:16] ^ 16'h4321};
      exp_pos     = 0;
      exp_verdict = lkdv_pkg::VERDICT_PENDING;
    end else begin
      p = d ^ exp_key1[7:0];
      r.plain = p;
      if (exp_verdict == lkdv_pkg::VERDICT_PENDING && exp_pos < CHECK_LEN) begin
        if (exp_pos == 0) ok = (p == MARK_BYTE);
        else ok = (p == 8'h00) || (p >= TEXT_LO && p <= TEXT_HI);
        if (!ok) exp_verdict = lkdv_pkg::VERDICT_REJECTED;
        else if (exp_pos == CHECK_LEN - 1) exp_verdict = lkdv_pkg::VERDICT_MATCHED;
        else if (l) exp_verdict = lkdv_pkg::VERDICT_REJECTED;
      end
      if (exp_pos < CHECK_LEN) exp_pos++;
      {exp_key1, exp_key2} = advance_keys(exp_key1, exp_key2);
    end
    r.verdict = exp_verdict;
    return r;
  endfunction

  always @(posedge clk) begin
    login_result_t want;
    if (rst) begin
      cur_a1      = 32'h383477BC;
      cur_a2      = 32'h383477BC;
      cur_b       = 32'h02345CC6;
      cur_mode    = 2'd0;
      exp_key1    = '0;
      exp_key2    = '0;
      exp_pos     = 0;
      exp_verdict = lkdv_pkg::VERDICT_PENDING;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lkdv_pkg::CFG_KEY_A1:      cur_a1 = cfg_data;
          lkdv_pkg::CFG_KEY_A2:      cur_a2 = cfg_data;
          lkdv_pkg::CFG_KEY_B:       cur_b = cfg_data;
          lkdv_pkg::CFG_CIPHER_MODE: cur_mode = cfg_data[1:0];
          default: ;
        endcase
      end
      // retire the result before queuing a new transaction from the same edge
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: plain_byte %h verdict %0d", plain_byte, verdict);
          err_count++;
        end else begin
          want = awaited_results.pop_front();
          seen_count++;
          if (plain_byte !== want.plain) begin
            $error("plain_byte mismatch: expected %h, actual %h", want.plain, plain_byte);
            err_count++;
          end
          if (verdict !== want.verdict) begin
            $error("verdict mismatch: expected %0d, actual %0d", want.verdict, verdict);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(decrypt_and_judge(command, seed, data_byte, last_byte));
    end
    outstanding     <= awaited_results.size();
    mismatches      <= err_count;
    results_checked <= seen_count;
  end

endmodule

// ----- tb/sv/login_keystream_decrypt_validate_core_test.sv -----
module login_keystream_decrypt_validate_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SINGLE   = 2'd0;
  localparam logic [1:0] MODE_DOUBLE   = 2'd1;
  localparam logic [1:0] MODE_POLY     = 2'd2;
  localparam logic [1:0] MODE_POLY_ALT = 2'd3;
  localparam logic [1:0] MODE_PLAN [8] = '{MODE_DOUBLE, MODE_POLY, MODE_SINGLE, MODE_POLY,
                                           MODE_POLY_ALT, MODE_SINGLE, MODE_DOUBLE, MODE_POLY};
  localparam int ITEM_TARGET = 600;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        command = lkdv_pkg::CMD_DATA;
  logic [31:0] seed = '0;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = lkdv_pkg::CFG_KEY_A1;
  logic [31:0] cfg_data = '0;
  logic        in_stall, out_valid, cfg_ready;
  logic [7:0]  plain_byte;
  logic [1:0]  verdict;

  int outstanding, mismatches, results_checked;

  // keystream mirror used only to encrypt chosen plaintext
  logic [31:0] gen_k1 = '0, gen_k2 = '0;
  logic [31:0] gen_a1 = lkdv_pkg::RST_KEY_A1, gen_a2 = lkdv_pkg::RST_KEY_A2;
  logic [31:0] gen_b = lkdv_pkg::RST_KEY_B;
  logic [1:0]  gen_mode = MODE_SINGLE;

  int items_sent, packets_sent, settings_used;
  int burst_left, stall_left, stall_style;

  login_keystream_decrypt_validate_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .seed       (seed),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .plain_byte (plain_byte),
    .verdict    (verdict),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lkdv_decrypt_monitor i_monitor (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .seed            (seed),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .plain_byte      (plain_byte),
    .verdict         (verdict),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .outstanding     (outstanding),
    .mismatches      (mismatches),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL login_keystream_decrypt_validate_core");
    $finish;
  end

  // receiver backpressure: free, light, heavy and solid stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 4);
      stall_left  <= $urandom_range(4, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      2: out_stall <= ($urandom_range(0, 3) == 0);
      3: out_stall <= ($urandom_range(0, 3) != 0);
      4: out_stall <= (stall_left > 30);
      default: out_stall <= 1'b0;
    endcase
  end

  function automatic void gen_advance();
    logic [31:0] k1sq, k2sq, shf, n1, n2;
    if (gen_mode[lkdv_pkg::MODE_BIT_POLY]) begin
      k1sq = gen_k1 * gen_k1;
      k2sq = gen_k2 * gen_k2;
      shf  = k2sq * 32'd5;
      n2   = (lkdv_pkg::POLY_N2A >> shf[4:0]) + gen_k2 * lkdv_pkg::POLY_N2A
           + k1sq * lkdv_pkg::POLY_N2M + lkdv_pkg::POLY_N2B;
      shf  = k1sq * 32'd3;
      n1   = (lkdv_pkg::POLY_N1A >> shf[4:0]) - (n2 * n2) * lkdv_pkg::POLY_N1M
           + gen_k1 * lkdv_pkg::POLY_N1A + lkdv_pkg::POLY_N1B;
    end else begin
      n2 = {gen_k1[0], gen_k2[31:1]} ^ gen_a1;
      if (gen_mode[lkdv_pkg::MODE_BIT_DOUBLE]) n2 = {gen_k1[0], n2[31:1]} ^ gen_a2;
      n1 = {gen_k2[0], gen_k1[31:1]} ^ gen_b;
    end
    gen_k1 = n1;
    gen_k2 = n2;
  endfunction

  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return lkdv_pkg::PRINT_LO;
      2: return lkdv_pkg::PRINT_HI;
      default: return 8'($urandom_range(8'h21, 8'h7D));
    endcase
  endfunction

  function automatic logic [7:0] junk_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h01, 8'h1F));
    return 8'($urandom_range(8'h7F, 8'hFF));
  endfunction

  task automatic drive_item(input logic cmd, input logic [31:0] s, input logic [7:0] d,
                            input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    seed      <= s;
    data_byte <= d;
    last_byte <= l;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (cmd == lkdv_pkg::CMD_START) begin
      gen_k1 = {~s[15:0] ^ lkdv_pkg::SEED_K1_HI, s[15:0] ^ lkdv_pkg::SEED_K1_LO};
      gen_k2 = {~s[31:16] ^ lkdv_pkg::SEED_K2_HI, s[31:16] ^ lkdv_pkg::SEED_K2_LO};
    end else begin
      gen_advance();
    end
  endtask

  task automatic send_start(input logic [31:0] s, input logic l);
    drive_item(lkdv_pkg::CMD_START, s, 8'($urandom), l);
  endtask

  task automatic send_plain(input logic [7:0] p, input logic l);
    drive_item(lkdv_pkg::CMD_DATA, $urandom, p ^ gen_k1[7:0], l);
  endtask

  // mostly well-formed logins; some short, some corrupted, some raw noise
  task automatic send_packet();
    int kind, len, bad_at;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      repeat ($urandom_range(1, 6))
        drive_item(1'($urandom), $urandom, 8'($urandom), 1'($urandom));
      return;
    end
    send_start($urandom, 1'($urandom));
    len = 31 + $urandom_range(0, 4);
    bad_at = -1;
    if (kind < 5) len = $urandom_range(1, 30);
    else if (kind < 8) bad_at = $urandom_range(0, 30);
    for (int i = 0; i < len; i++) begin
      if (i == bad_at)
        send_plain((i == 0) ? lkdv_pkg::PLAIN_MARK ^ 8'($urandom_range(1, 255)) : junk_byte(),
                   i == len - 1);
      else
        send_plain((i == 0) ? lkdv_pkg::PLAIN_MARK : text_byte(), i == len - 1);
    end
    packets_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // polynomial key update can still be running after the last result
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_key_set(input logic [31:0] a1, input logic [31:0] a2, input logic [31:0] b,
                              input logic [1:0] mode);
    logic [31:0] mode_word;
    settle();
    mode_word = $urandom;
    mode_word[1:0] = mode;
    write_reg(lkdv_pkg::CFG_KEY_A1, a1);
    write_reg(lkdv_pkg::CFG_KEY_A2, a2);
    write_reg(lkdv_pkg::CFG_KEY_B, b);
    write_reg(lkdv_pkg::CFG_CIPHER_MODE, mode_word);
    cfg_valid <= 1'b0;
    gen_a1 = a1;
    gen_a2 = a2;
    gen_b = b;
    gen_mode = mode;
    settings_used++;
  endtask

  initial begin
    int phase_end, waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // data ahead of any start runs on the cleared keys
    send_plain(lkdv_pkg::PLAIN_MARK, 1'b0);
    send_plain(8'h41, 1'b0);
    send_start(32'h0000_0000, 1'b1);
    // short packet
    send_plain(lkdv_pkg::PLAIN_MARK, 1'b0);
    send_plain(lkdv_pkg::PRINT_LO, 1'b0);
    send_plain(lkdv_pkg::PRINT_HI, 1'b0);
    send_plain(8'h00, 1'b1);
    // one bad byte rejects, later bytes leave the verdict alone
    send_start(32'hFFFF_FFFF, 1'b0);
    send_plain(lkdv_pkg::PLAIN_MARK, 1'b0);
    send_plain(8'h1F, 1'b0);
    send_plain(8'h7F, 1'b0);
    send_plain(8'hFF, 1'b1);
    // wrong mark byte
    send_start(32'h5A5A_A5A5, 1'b0);
    send_plain(8'h7F, 1'b0);
    send_plain(8'h21, 1'b0);
    drive_item(lkdv_pkg::CMD_DATA, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    drive_item(lkdv_pkg::CMD_DATA, 32'h0000_0000, 8'h00, 1'b0);

    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      case (phase % 8)
        1: load_key_set('1, '1, '1, MODE_PLAN[1]);
        2: load_key_set('0, '0, '0, MODE_PLAN[2]);
        default: load_key_set($urandom, $urandom, $urandom, MODE_PLAN[phase % 8]);
      endcase
      phase_end = items_sent + 85;
      while (items_sent < phase_end) send_packet();
    end

    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    for (waited = 0; waited < 5000 && outstanding != 0; waited++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (outstanding != 0) $error("%0d results never arrived", outstanding);
    $display("Drove %0d transactions (%0d login packets plus noise) under %0d key-set settings",
             items_sent, packets_sent, settings_used);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS login_keystream_decrypt_validate_core");
    end else begin
      $display("FAIL login_keystream_decrypt_validate_core");
    end
    $finish;
  end

endmodule

// ----- login_keystream_decrypt_validate_core.f -----
+incdir+src
src/lkdv_pkg.sv
src/lkdv_mul.sv
src/lkdv_poly.sv
src/login_keystream_decrypt_validate_core.sv
tb/sv/lkdv_decrypt_monitor.sv
tb/sv/login_keystream_decrypt_validate_core_test.sv
